// ===== design/lcd_pkg.sv =====
// Shared types, constants and helper functions of the layered centroid distance block.
// Used by lcd_ctrl, lcd_dpath and the top level; depends on nothing.
`timescale 1ns / 1ps

package lcd_pkg;

    localparam int MAX_DIMS     = 16;
    localparam int MAX_CLUSTERS = 16;
    localparam int MAX_LAYERS   = 4;
    localparam int DATA_W       = 32;
    localparam int IDX_W        = 4;
    localparam int LAYER_W      = 2;
    localparam int CNT_W        = 5;
    localparam int NL_W         = 3;
    localparam int CADDR_W      = LAYER_W + IDX_W + IDX_W;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 5;

    localparam logic [1:0] ACT_LO     = 2'd0;
    localparam logic [1:0] ACT_HI     = 2'd1;
    localparam logic [1:0] ACT_CENT   = 2'd2;
    localparam logic [1:0] ACT_SAMPLE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALING = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYERS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUTS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_L0      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_L1      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_L2      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_L3      = 3'd6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic               load_en;
        logic               div_start;
        logic               prep_write;
        logic               prep_scaled;
        logic               sum_clr;
        logic               diff_en;
        logic               mul_en;
        logic               acc_en;
        logic               sqrt_start;
        logic               dist_write;
        logic               out_load;
        logic               sel;
        logic               layer_unsigned;
        logic [LAYER_W-1:0] layer;
        logic [IDX_W-1:0]   clus;
        logic [IDX_W-1:0]   elem;
        logic [IDX_W-1:0]   outk;
        logic               out_last;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic sqrt_busy;
    } t_status;

    // Counts of zero act as one; counts above the maximum act as the maximum.
    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = v;
        if (v == '0) r = CNT_W'(1);
        else if (v > CNT_W'(MAX_CLUSTERS)) r = CNT_W'(MAX_CLUSTERS);
        return r;
    endfunction

    function automatic logic [NL_W-1:0] clamp_layers(input logic [NL_W-1:0] v);
        logic [NL_W-1:0] r;
        r = v;
        if (v == '0) r = NL_W'(1);
        else if (v > NL_W'(MAX_LAYERS)) r = NL_W'(MAX_LAYERS);
        return r;
    endfunction

endpackage

// ===== design/lcd_div.sv =====
// Iterative restoring divider for range scaling: ((num << 16) / den), truncated, saturated.
// One quotient bit per cycle; uses lcd_pkg.
`timescale 1ns / 1ps

module lcd_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_num,
    input  logic [32:0] i_den,
    output logic        o_busy,
    output logic [31:0] o_quot
);
    import lcd_pkg::*;

    localparam int QW = 49;

    logic          r_busy, n_busy;
    logic [5:0]    r_cnt, n_cnt;
    logic [33:0]   r_rem, n_rem;
    logic [QW-1:0] r_quo, n_quo;
    logic [32:0]   r_dvs, n_dvs;
    logic          r_neg, n_neg;
    logic          r_zero, n_zero;
    logic [32:0]   w_num_abs, w_den_abs;
    logic [33:0]   w_trial;

    assign w_num_abs = i_num[32] ? (~i_num + 33'd1) : i_num;
    assign w_den_abs = i_den[32] ? (~i_den + 33'd1) : i_den;
    assign w_trial   = {r_rem[32:0], r_quo[QW-1]};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        n_neg  = r_neg;
        n_zero = r_zero;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 6'(QW - 1);
            n_rem  = '0;
            n_quo  = {w_num_abs, 16'h0};
            n_dvs  = w_den_abs;
            n_neg  = i_num[32] ^ i_den[32];
            n_zero = (i_den == '0);
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_dvs}) begin
                n_rem = w_trial - {1'b0, r_dvs};
                n_quo = {r_quo[QW-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_quo = {r_quo[QW-2:0], 1'b0};
            end
            if (r_cnt == '0) n_busy = 1'b0;
            else n_cnt = r_cnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_dvs  <= n_dvs;
        r_neg  <= n_neg;
        r_zero <= n_zero;
    end

    // Sign and saturate the magnitude quotient to signed Q16.16.
    always_comb begin
        if (r_zero) begin
            o_quot = '0;
        end else if (r_neg) begin
            if (r_quo > QW'(33'h080000000)) o_quot = 32'h8000_0000;
            else o_quot = ~r_quo[31:0] + 32'd1;
        end else begin
            if (r_quo >= QW'(33'h080000000)) o_quot = 32'h7FFF_FFFF;
            else o_quot = r_quo[31:0];
        end
    end

    assign o_busy = r_busy;

endmodule

// ===== design/lcd_sqrt.sv =====
// Digit-by-digit integer square root of a 64-bit value, two radicand bits per cycle.
// Gives the floor of the root; uses lcd_pkg.
`timescale 1ns / 1ps

module lcd_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_value,
    output logic        o_busy,
    output logic [31:0] o_root
);
    import lcd_pkg::*;

    logic        r_busy, n_busy;
    logic [4:0]  r_cnt, n_cnt;
    logic [63:0] r_rad, n_rad;
    logic [34:0] r_rem, n_rem;
    logic [31:0] r_root, n_root;
    logic [34:0] w_shift, w_trial;

    assign w_shift = {r_rem[32:0], r_rad[63:62]};
    assign w_trial = {1'b0, r_root, 2'b01};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 5'd31;
            n_rad  = i_value;
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            n_rad = {r_rad[61:0], 2'b00};
            if (w_shift >= w_trial) begin
                n_rem  = w_shift - w_trial;
                n_root = {r_root[30:0], 1'b1};
            end else begin
                n_rem  = w_shift;
                n_root = {r_root[30:0], 1'b0};
            end
            if (r_cnt == '0) n_busy = 1'b0;
            else n_cnt = r_cnt - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_cnt  <= n_cnt;
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

// ===== design/lcd_ctrl.sv =====
// Controller of the layered centroid distance block: configuration registers and sequencer.
// Drives lcd_dpath through lcd_pkg::t_cmd and reads lcd_pkg::t_status.
`timescale 1ns / 1ps

module lcd_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [1:0]                       i_action,
    input  logic [lcd_pkg::IDX_W-1:0]        i_dim_index,
    input  logic                             i_cfg_we,
    input  logic [lcd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lcd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                             o_valid,
    input  logic                             i_stall,
    output lcd_pkg::t_cmd                    o_cmd,
    input  lcd_pkg::t_status                 i_status
);
    import lcd_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PREP = 4'd1;
    localparam logic [3:0] S_DIVW = 4'd2;
    localparam logic [3:0] S_CLR  = 4'd3;
    localparam logic [3:0] S_RD   = 4'd4;
    localparam logic [3:0] S_DIFF = 4'd5;
    localparam logic [3:0] S_MUL  = 4'd6;
    localparam logic [3:0] S_ACC  = 4'd7;
    localparam logic [3:0] S_SQS  = 4'd8;
    localparam logic [3:0] S_SQW  = 4'd9;
    localparam logic [3:0] S_OUTL = 4'd10;
    localparam logic [3:0] S_OUTW = 4'd11;

    logic [3:0]         r_state, n_state;
    logic               r_use_scaling;
    logic [NL_W-1:0]    r_num_layers;
    logic [CNT_W-1:0]   r_input_count;
    logic [CNT_W-1:0]   r_clusters [MAX_LAYERS];
    logic [IDX_W-1:0]   r_j, n_j, r_i, n_i, r_k, n_k;
    logic [LAYER_W-1:0] r_layer, n_layer;
    logic               r_sel, n_sel;
    logic [CNT_W-1:0]   r_nin, n_nin;
    logic               r_valid, n_valid;
    logic [CNT_W-1:0]   w_nin0, w_m;
    logic [NL_W-1:0]    w_nl;
    logic               w_j_last, w_i_last, w_k_last, w_l_last;

    assign w_nin0   = clamp_count(r_input_count);
    assign w_m      = clamp_count(r_clusters[r_layer]);
    assign w_nl     = clamp_layers(r_num_layers);
    assign w_j_last = ({1'b0, r_j} == r_nin - CNT_W'(1));
    assign w_i_last = ({1'b0, r_i} == w_m - CNT_W'(1));
    assign w_k_last = ({1'b0, r_k} == r_nin - CNT_W'(1));
    assign w_l_last = ({1'b0, r_layer} == w_nl - NL_W'(1));

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;

    always_comb begin
        n_state = r_state;
        n_j     = r_j;
        n_i     = r_i;
        n_k     = r_k;
        n_layer = r_layer;
        n_sel   = r_sel;
        n_nin   = r_nin;
        n_valid = r_valid;
        o_cmd   = '0;
        o_cmd.sel            = r_sel;
        o_cmd.layer_unsigned = (r_layer != '0);
        o_cmd.layer          = r_layer;
        o_cmd.clus           = r_i;
        o_cmd.elem           = r_j;
        o_cmd.outk           = r_k;
        o_cmd.out_last       = w_k_last;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_en = 1'b1;
                    if (i_action == ACT_SAMPLE &&
                        {1'b0, i_dim_index} == w_nin0 - CNT_W'(1)) begin
                        n_j     = '0;
                        n_sel   = 1'b0;
                        n_nin   = w_nin0;
                        n_state = S_PREP;
                    end
                end
            end
            S_PREP, S_DIVW: begin
                if (r_state == S_PREP && r_use_scaling) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIVW;
                end else if (r_state == S_PREP || !i_status.div_busy) begin
                    o_cmd.prep_write  = 1'b1;
                    o_cmd.prep_scaled = (r_state == S_DIVW);
                    if (w_j_last) begin
                        n_j     = '0;
                        n_i     = '0;
                        n_layer = '0;
                        n_state = S_CLR;
                    end else begin
                        n_j     = r_j + IDX_W'(1);
                        n_state = S_PREP;
                    end
                end
            end
            S_CLR: begin
                o_cmd.sum_clr = 1'b1;
                n_j     = '0;
                n_state = S_RD;
            end
            S_RD:   n_state = S_DIFF;
            S_DIFF: begin
                o_cmd.diff_en = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_en = 1'b1;
                if (w_j_last) begin
                    n_state = S_SQS;
                end else begin
                    n_j     = r_j + IDX_W'(1);
                    n_state = S_RD;
                end
            end
            S_SQS: begin
                o_cmd.sqrt_start = 1'b1;
                n_state = S_SQW;
            end
            S_SQW: begin
                if (!i_status.sqrt_busy) begin
                    o_cmd.dist_write = 1'b1;
                    if (w_i_last) begin
                        n_sel = ~r_sel;
                        n_nin = w_m;
                        if (w_l_last) begin
                            n_k     = '0;
                            n_state = S_OUTL;
                        end else begin
                            n_layer = r_layer + LAYER_W'(1);
                            n_i     = '0;
                            n_state = S_CLR;
                        end
                    end else begin
                        n_i     = r_i + IDX_W'(1);
                        n_state = S_CLR;
                    end
                end
            end
            S_OUTL: begin
                o_cmd.out_load = 1'b1;
                n_valid = 1'b1;
                n_state = S_OUTW;
            end
            S_OUTW: begin
                if (!i_stall) begin
                    n_valid = 1'b0;
                    if (w_k_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + IDX_W'(1);
                        n_state = S_OUTL;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_valid       <= 1'b0;
            r_use_scaling <= 1'b0;
            r_num_layers  <= NL_W'(1);
            r_input_count <= CNT_W'(16);
            for (int l = 0; l < MAX_LAYERS; l++) r_clusters[l] <= CNT_W'(16);
            r_j     <= '0;
            r_i     <= '0;
            r_k     <= '0;
            r_layer <= '0;
            r_sel   <= 1'b0;
            r_nin   <= CNT_W'(1);
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_j     <= n_j;
            r_i     <= n_i;
            r_k     <= n_k;
            r_layer <= n_layer;
            r_sel   <= n_sel;
            r_nin   <= n_nin;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SCALING: r_use_scaling  <= i_cfg_data[0];
                    CFG_LAYERS:  r_num_layers   <= i_cfg_data[NL_W-1:0];
                    CFG_INPUTS:  r_input_count  <= i_cfg_data;
                    CFG_L0:      r_clusters[0]  <= i_cfg_data;
                    CFG_L1:      r_clusters[1]  <= i_cfg_data;
                    CFG_L2:      r_clusters[2]  <= i_cfg_data;
                    CFG_L3:      r_clusters[3]  <= i_cfg_data;
                    default:     ;
                endcase
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_valid_only_in_outw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == S_OUTW))
        else $error("result valid outside the output wait state");
    a_div_only_scaling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVW) |-> r_use_scaling)
        else $error("divider wait without scaling enabled");
    a_last_back_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_stall && w_k_last) |=> (r_state == S_IDLE))
        else $error("no return to idle after the last result");
    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ({1'b0, r_k} < r_nin))
        else $error("result index beyond centroid count");
`endif

endmodule

// ===== design/lcd_dpath.sv =====
// Datapath: centroid memory, range and sample stores, layer buffers, squared-difference
// accumulator, divider and square root. Uses lcd_pkg, lcd_div and lcd_sqrt.
`timescale 1ns / 1ps

module lcd_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [1:0]                    i_action,
    input  logic [lcd_pkg::LAYER_W-1:0]   i_layer_index,
    input  logic [lcd_pkg::IDX_W-1:0]     i_cluster_index,
    input  logic [lcd_pkg::IDX_W-1:0]     i_dim_index,
    input  logic signed [31:0]            i_sample_value,
    input  lcd_pkg::t_cmd                 i_cmd,
    output lcd_pkg::t_status              o_status,
    output logic [lcd_pkg::IDX_W-1:0]     o_cluster_number,
    output logic [31:0]                   o_distance,
    output logic                          o_last_result
);
    import lcd_pkg::*;

    logic [DATA_W-1:0] r_cent [1 << CADDR_W];
    logic [DATA_W-1:0] r_lo   [MAX_DIMS];
    logic [DATA_W-1:0] r_hi   [MAX_DIMS];
    logic [DATA_W-1:0] r_samp [MAX_DIMS];
    logic [DATA_W-1:0] r_buf  [2][MAX_CLUSTERS];

    logic [DATA_W-1:0] r_cdata, r_vin, r_absd;
    logic              r_sat;
    logic [63:0]       r_sq, r_sum;
    logic [IDX_W-1:0]  r_o_num;
    logic [31:0]       r_o_dist;
    logic              r_o_last;

    logic [DATA_W-1:0] w_x, w_lo, w_hi;
    logic [32:0]       w_num, w_den, w_vin33;
    logic [33:0]       w_diff, w_abs;
    logic [63:0]       w_prod;
    logic [64:0]       w_acc;
    logic [31:0]       w_quot, w_root;
    logic              w_div_busy, w_sqrt_busy;

    assign w_x  = r_samp[i_cmd.elem];
    assign w_lo = r_lo[i_cmd.elem];
    assign w_hi = r_hi[i_cmd.elem];
    assign w_num = {w_x[31], w_x} - {w_lo[31], w_lo};
    assign w_den = {w_hi[31], w_hi} - {w_lo[31], w_lo};

    // Later layers take unsigned distances, the first layer signed elements.
    assign w_vin33 = i_cmd.layer_unsigned ? {1'b0, r_vin} : {r_vin[31], r_vin};
    assign w_diff  = {w_vin33[32], w_vin33} - {{2{r_cdata[31]}}, r_cdata};
    assign w_abs   = w_diff[33] ? (~w_diff + 34'd1) : w_diff;
    assign w_prod  = r_absd * r_absd;
    assign w_acc   = {1'b0, r_sum} + {1'b0, r_sq};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_en && i_action == ACT_CENT) begin
            r_cent[{i_layer_index, i_cluster_index, i_dim_index}] <= i_sample_value;
        end
        r_cdata <= r_cent[{i_cmd.layer, i_cmd.clus, i_cmd.elem}];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_en) begin
            case (i_action)
                ACT_LO:     r_lo[i_dim_index]   <= i_sample_value;
                ACT_HI:     r_hi[i_dim_index]   <= i_sample_value;
                ACT_SAMPLE: r_samp[i_dim_index] <= i_sample_value;
                default:    ;
            endcase
        end
        if (i_cmd.prep_write) begin
            r_buf[0][i_cmd.elem] <= i_cmd.prep_scaled ? w_quot : w_x;
        end else if (i_cmd.dist_write) begin
            r_buf[~i_cmd.sel][i_cmd.clus] <= w_root;
        end
        r_vin <= r_buf[i_cmd.sel][i_cmd.elem];
        if (i_cmd.diff_en) begin
            r_sat  <= (w_abs[33:32] != 2'b00);
            r_absd <= w_abs[31:0];
        end
        if (i_cmd.mul_en) r_sq <= r_sat ? '1 : w_prod;
        if (i_cmd.sum_clr) r_sum <= '0;
        else if (i_cmd.acc_en) r_sum <= w_acc[64] ? '1 : w_acc[63:0];
        if (i_cmd.out_load) begin
            r_o_num  <= i_cmd.outk;
            r_o_dist <= r_buf[i_cmd.sel][i_cmd.outk];
            r_o_last <= i_cmd.out_last;
        end
    end

    lcd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    lcd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_value (r_sum),
        .o_busy  (w_sqrt_busy),
        .o_root  (w_root)
    );

    assign o_status.div_busy  = w_div_busy;
    assign o_status.sqrt_busy = w_sqrt_busy;
    assign o_cluster_number   = r_o_num;
    assign o_distance         = r_o_dist;
    assign o_last_result      = r_o_last;

endmodule

// ===== design/layered_centroid_distance.sv =====
// Top level of the layered centroid distance block.
// Joins lcd_ctrl and lcd_dpath; uses lcd_pkg.
`timescale 1ns / 1ps

// Layered centroid distance. Requests on the input channel either load a range
// bound, load one centroid element, or deliver one sample element. Loads and
// sample elements that do not complete a sample are taken without a stall. The
// element at position input_count-1 completes the sample: the block then stalls
// its input while it works. With N inputs it first copies the sample element by
// element, passing each element through the one-bit-per-cycle divider when
// scaling is on. Each layer then computes, for each of its M centroids, a sum of
// squares over its N inputs on one shared multiplier, taking each element
// through read, difference, square and accumulate steps, followed by a square
// root, where N is the previous layer's M beyond the first layer. The final
// layer's distances leave one at a time through an output register, each held
// while the receiver stalls. Distances are unsigned Q16.16 and saturate at the
// maximum. Configuration must be written only while the block is idle; the block
// does not enforce this. Stored ranges and centroids hold no defined value
// until loaded.
module layered_centroid_distance (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [1:0]                       i_action,
    input  logic [lcd_pkg::LAYER_W-1:0]      i_layer_index,
    input  logic [lcd_pkg::IDX_W-1:0]        i_cluster_index,
    input  logic [lcd_pkg::IDX_W-1:0]        i_dim_index,
    input  logic signed [31:0]               i_sample_value,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [lcd_pkg::IDX_W-1:0]        o_cluster_number,
    output logic [31:0]                      o_distance,
    output logic                             o_last_result,
    input  logic                             i_cfg_we,
    input  logic [lcd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lcd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import lcd_pkg::*;

    // The controller sequences everything; the datapath only follows commands.
    t_cmd    w_cmd;
    t_status w_status;

    lcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_action    (i_action),
        .i_dim_index (i_dim_index),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    lcd_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_action         (i_action),
        .i_layer_index    (i_layer_index),
        .i_cluster_index  (i_cluster_index),
        .i_dim_index      (i_dim_index),
        .i_sample_value   (i_sample_value),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .o_cluster_number (o_cluster_number),
        .o_distance       (o_distance),
        .o_last_result    (o_last_result)
    );

endmodule

// ===== tb/sv/layered_centroid_distance_test.sv =====
// Self-checking testbench for the layered centroid distance block.
// Depends on lcd_pkg and layered_centroid_distance; reads no files.
`timescale 1ns / 1ps

module layered_centroid_distance_test;
    import lcd_pkg::*;

    // One input request and one distance result, at the port widths.
    typedef struct {
        logic [1:0]  act;
        logic [1:0]  lay;
        logic [3:0]  clus;
        logic [3:0]  dim;
        logic [31:0] val;
    } request_t;

    typedef struct {
        logic [3:0]  cnum;
        logic [31:0] dval;
        logic        last;
    } distance_t;

    localparam longint unsigned SUM_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int HOLD_CYCLES = 3000;

    bit                   i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [1:0]           i_action = ACT_LO;
    logic [LAYER_W-1:0]   i_layer_index = '0;
    logic [IDX_W-1:0]     i_cluster_index = '0;
    logic [IDX_W-1:0]     i_dim_index = '0;
    logic signed [31:0]   i_sample_value = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [IDX_W-1:0]     o_cluster_number;
    logic [31:0]          o_distance;
    logic                 o_last_result;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_SCALING;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    layered_centroid_distance dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_action(i_action), .i_layer_index(i_layer_index),
        .i_cluster_index(i_cluster_index), .i_dim_index(i_dim_index),
        .i_sample_value(i_sample_value),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_cluster_number(o_cluster_number), .o_distance(o_distance),
        .o_last_result(o_last_result),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Requests waiting to be sent and distances waiting to arrive.
    request_t  req_pending[$];
    distance_t dist_expected[$];
    int        mismatches = 0;
    int        idle_pct = 37;
    int        hold_req = 0;

    // Shadow copy of the block's stores and registers.
    logic [31:0] cent_mem [4][16][16];
    logic [31:0] lo_mem [16];
    logic [31:0] hi_mem [16];
    logic [31:0] sample_mem [16];
    logic        scal_reg = 1'b0;
    logic [2:0]  layers_reg = 3'd1;
    logic [4:0]  inputs_reg = 5'd16;
    logic [4:0]  clus_reg [4] = '{5'd16, 5'd16, 5'd16, 5'd16};

    // A zero count acts as one and large counts act as the store size.
    function automatic int eff_count(input int v, input int top);
        if (v == 0) return 1;
        if (v > top) return top;
        return v;
    endfunction

    // Bitwise integer square root, one result bit per step.
    function automatic logic [31:0] floor_root(input longint unsigned v);
        longint unsigned acc = 0;
        longint unsigned bitv = 64'h4000_0000_0000_0000;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= acc + bitv) begin
                v = v - (acc + bitv);
                acc = (acc >> 1) + bitv;
            end else begin
                acc = acc >> 1;
            end
            bitv = bitv >> 2;
        end
        return acc[31:0];
    endfunction

    // Applies one accepted request to the shadow state and queues the
    // distances that a completed sample produces.
    task automatic predict_distances(input request_t r);
        longint vec [16];
        logic [31:0] dist_v [16];
        longint d, span, q, lo, hi;
        longint unsigned sum, ad, sq;
        int n, m, nl;
        distance_t e;
        case (r.act)
            ACT_LO: lo_mem[r.dim] = r.val;
            ACT_HI: hi_mem[r.dim] = r.val;
            ACT_CENT: cent_mem[r.lay][r.clus][r.dim] = r.val;
            default: begin
                sample_mem[r.dim] = r.val;
                n = eff_count(inputs_reg, MAX_DIMS);
                if (r.dim == n - 1) begin
                    for (int j = 0; j < n; j++) begin
                        vec[j] = longint'($signed(sample_mem[j]));
                        if (scal_reg) begin
                            lo = longint'($signed(lo_mem[j]));
                            hi = longint'($signed(hi_mem[j]));
                            span = hi - lo;
                            if (span == 0) begin
                                vec[j] = 0;
                            end else begin
                                q = ((vec[j] - lo) * 65536) / span;
                                if (q > 64'sd2147483647) q = 64'sd2147483647;
                                if (q < -64'sd2147483648) q = -64'sd2147483648;
                                vec[j] = q;
                            end
                        end
                    end
                    nl = eff_count(layers_reg, MAX_LAYERS);
                    m = 1;
                    for (int l = 0; l < nl; l++) begin
                        m = eff_count(clus_reg[l], MAX_CLUSTERS);
                        for (int k = 0; k < m; k++) begin
                            sum = 0;
                            for (int j = 0; j < n; j++) begin
                                d = vec[j] - longint'($signed(cent_mem[l][k][j]));
                                ad = (d < 0) ? longint'(-d) : d;
                                sq = (ad >= 64'h1_0000_0000) ? SUM_MAX : ad * ad;
                                sum = (sum > SUM_MAX - sq) ? SUM_MAX : sum + sq;
                            end
                            dist_v[k] = floor_root(sum);
                        end
                        // Distances feed the next layer as unsigned values.
                        for (int k = 0; k < m; k++) vec[k] = longint'({32'b0, dist_v[k]});
                        n = m;
                    end
                    for (int k = 0; k < m; k++) begin
                        e.cnum = k[3:0];
                        e.dval = dist_v[k];
                        e.last = (k == m - 1);
                        dist_expected = {dist_expected, e};
                    end
                end
            end
        endcase
    endtask

    // Reset is held at the start, then released and never asserted again.
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver: a request is accepted when valid is high and the block does not
    // stall. A held request keeps its payload until it is taken.
    always @(posedge i_clk) begin
        request_t r;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                r.act = i_action;
                r.lay = i_layer_index;
                r.clus = i_cluster_index;
                r.dim = i_dim_index;
                r.val = i_sample_value;
                predict_distances(r);
            end
            if (!i_valid || !o_stall) begin
                if (req_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    r = req_pending.pop_front();
                    i_action <= r.act;
                    i_layer_index <= r.lay;
                    i_cluster_index <= r.clus;
                    i_dim_index <= r.dim;
                    i_sample_value <= r.val;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall: random, or a long hold-off when one is requested.
    int hold_seen = 0;
    int hold_left = 0;
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    // Monitor: every accepted result is checked against the oldest expectation.
    always @(posedge i_clk) begin
        distance_t e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (dist_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: cluster %0d distance %h last %b",
                             o_cluster_number, o_distance, o_last_result);
            end else begin
                e = dist_expected.pop_front();
                if (o_cluster_number !== e.cnum || o_distance !== e.dval
                        || o_last_result !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected cluster %0d distance %h last %b, got %0d %h %b",
                                 e.cnum, e.dval, e.last,
                                 o_cluster_number, o_distance, o_last_result);
                end
            end
        end
    end

    // Mixes extremes, small Q16.16 values and fully random words.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3, 4, 5: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic request_t make_req(input logic [1:0] act, input int lay,
                                          input int clus, input int dim,
                                          input logic [31:0] val);
        request_t r;
        r.act = act;
        r.lay = lay[1:0];
        r.clus = clus[3:0];
        r.dim = dim[3:0];
        r.val = val;
        return r;
    endfunction

    // Waits until all requests are sent and all results checked, then lets the
    // block finish any trailing load before the next register write.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (req_pending.size() != 0 || i_valid || dist_expected.size() != 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[CFG_DATA_W-1:0];
        case (idx)
            CFG_SCALING: scal_reg = val[0];
            CFG_LAYERS: layers_reg = val[2:0];
            CFG_INPUTS: inputs_reg = val[4:0];
            CFG_L0: clus_reg[0] = val[4:0];
            CFG_L1: clus_reg[1] = val[4:0];
            CFG_L2: clus_reg[2] = val[4:0];
            default: clus_reg[3] = val[4:0];
        endcase
    endtask

    task automatic set_config(input int scal, input int nl, input int ic,
                              input int c0, input int c1, input int c2, input int c3);
        write_reg(CFG_SCALING, scal);
        write_reg(CFG_LAYERS, nl);
        write_reg(CFG_INPUTS, ic);
        write_reg(CFG_L0, c0);
        write_reg(CFG_L1, c1);
        write_reg(CFG_L2, c2);
        write_reg(CFG_L3, c3);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Counts stay within the loaded part of the centroid store; a zero
    // now and then exercises the clamping to one.
    function automatic int pick_count();
        if ($urandom_range(9) == 0) return 0;
        return $urandom_range(1, 4);
    endfunction

    // Queues samples until the phase has enough requests. Most are complete
    // samples in order; some arrive shuffled, and some requests are noise.
    task automatic fill_samples(input int want);
        int sent, n, kind, order [16], tmp, p;
        sent = 0;
        n = eff_count(inputs_reg, MAX_DIMS);
        while (sent < want) begin
            kind = $urandom_range(99);
            if (kind < 12) begin
                req_pending = {req_pending, make_req(2'($urandom_range(3)),
                    $urandom_range(3), $urandom_range(15), $urandom_range(15),
                    pick_value())};
                sent++;
            end else begin
                for (int j = 0; j < n; j++) order[j] = j;
                if (kind < 22) begin
                    for (int j = n - 1; j > 0; j--) begin
                        p = $urandom_range(j);
                        tmp = order[j];
                        order[j] = order[p];
                        order[p] = tmp;
                    end
                end
                for (int j = 0; j < n; j++)
                    req_pending = {req_pending, make_req(ACT_SAMPLE, $urandom_range(3),
                        $urandom_range(15), order[j], pick_value())};
                sent += n;
            end
        end
    endtask

    initial begin
        logic [31:0] lo, hi;
        @(posedge i_rst_n);

        // Fill every range entry. The first dimensions carry the scaling
        // corner cases: equal bounds, the full signed span, reversed bounds
        // and a span so narrow that the quotient saturates.
        for (int d = 0; d < 16; d++) begin
            case (d)
                0: begin lo = 32'h0001_0000; hi = 32'h0001_0000; end
                1: begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; end
                2: begin lo = 32'h0005_0000; hi = 32'h0001_0000; end
                3: begin lo = 32'h0000_0000; hi = 32'h0000_0001; end
                default: begin
                    lo = -$urandom_range(32'h0003_0000);
                    hi = $urandom_range(32'h0003_0000);
                end
            endcase
            req_pending = {req_pending,
                make_req(ACT_LO, $urandom_range(3), $urandom_range(15), d, lo)};
            req_pending = {req_pending,
                make_req(ACT_HI, $urandom_range(3), $urandom_range(15), d, hi)};
        end
        // Centroids: the first four of every layer over four elements, plus
        // the first centroid of the first layer over all elements and every
        // centroid of the last layer over the first element.
        for (int l = 0; l < 4; l++)
            for (int c = 0; c < 16; c++)
                for (int d = 0; d < 16; d++)
                    if ((c < 4 && d < 4) || (l == 0 && c == 0) || (l == 3 && d == 0))
                        req_pending = {req_pending, make_req(ACT_CENT, l, c, d, pick_value())};
        wait_idle();

        // Scaling and layer count still at their reset values. The fourth
        // element completes the sample; the later ones are only stored.
        write_reg(CFG_INPUTS, 4);
        write_reg(CFG_L0, 4);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        for (int d = 0; d < 16; d++) begin
            case (d)
                0: lo = 32'h8000_0000;
                1: lo = 32'h7FFF_FFFF;
                2: lo = 32'h0000_0000;
                3: lo = 32'hFFFF_FFFF;
                default: lo = pick_value();
            endcase
            req_pending = {req_pending, make_req(ACT_SAMPLE, d % 4, 15 - d, d, lo)};
        end
        wait_idle();

        // All registers zero: counts act as one. An element past the sample
        // length is stored without completing anything.
        set_config(0, 0, 0, 0, 0, 0, 0);
        req_pending = {req_pending, make_req(ACT_SAMPLE, 3, 15, 9, 32'h1234_5678)};
        req_pending = {req_pending, make_req(ACT_SAMPLE, 0, 0, 0, 32'h7FFF_FFFF)};
        req_pending = {req_pending, make_req(ACT_SAMPLE, 2, 7, 0, 32'h8000_0000)};
        wait_idle();

        // Oversized register values with scaling: all sixteen elements, four
        // layers and sixteen centroids in the last layer.
        // One element completes the sample from the elements already stored.
        set_config(1, 7, 31, 1, 2, 1, 31);
        req_pending = {req_pending, make_req(ACT_SAMPLE, 1, 3, 15, 32'h0000_8000)};
        wait_idle();
        set_config(1, 4, 16, 1, 4, 4, 4);
        req_pending = {req_pending, make_req(ACT_SAMPLE, 1, 3, 15, 32'hFFFF_0000)};
        wait_idle();

        for (int p = 0; p < 10; p++) begin
            set_config($urandom_range(1), $urandom_range(7), pick_count(), pick_count(),
                       pick_count(), pick_count(), pick_count());
            idle_pct = (p == 2) ? 0 : 37;
            if (p == 4) hold_req++;
            if (p == 6) begin
                // The sender stops halfway until every result has come back.
                fill_samples(6);
                wait_idle();
                fill_samples(6);
            end else begin
                fill_samples(12);
            end
            wait_idle();
        end

        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && dist_expected.size() == 0) begin
            $display("layered_centroid_distance_test OK");
        end else begin
            $display("layered_centroid_distance_test NOT OK");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #40_000_000;
        $display("layered_centroid_distance_test NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
design/lcd_pkg.sv
design/lcd_div.sv
design/lcd_sqrt.sv
design/lcd_ctrl.sv
design/lcd_dpath.sv
design/layered_centroid_distance.sv
tb/sv/layered_centroid_distance_test.sv
